[rtl/tsq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack queue package
// Shared types and constants for the queue built from two bounded stacks.
// ----------------------------------------------------------------------------
package tsq_pkg;

   localparam int DATA_WIDTH          = 32;
   localparam int STACK_DEPTH_DEFAULT = 128;

   localparam logic [DATA_WIDTH-1:0] EMPTY_VALUE = {DATA_WIDTH{1'b1}};

   typedef enum logic {
      ACTION_ENQ = 1'b0,
      ACTION_DEQ = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_ENQ   = 2'd0,
      STATUS_DROP  = 2'd1,
      STATUS_DEQ   = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_POP,
      ST_POP_WAIT
   } state_type;

   typedef struct packed {
      logic enq;
      logic move_rd;
      logic move_wr;
      logic pop_rd;
      logic load_pop;
      logic load_empty;
   } cmd_type;

   typedef struct packed {
      logic in_empty;
      logic out_empty;
      logic move_pend;
      logic rsp_valid;
   } flags_type;

endpackage

[rtl/tsq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack queue channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tsq_req_if import tsq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic signed [DATA_WIDTH-1:0] item_value;

   modport source (output valid, output action, output item_value, input ready);
   modport sink (input valid, input action, input item_value, output ready);
endinterface

interface tsq_rsp_if import tsq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic signed [DATA_WIDTH-1:0] out_value;

   modport source (output valid, output status, output out_value, input ready);
   modport sink (input valid, input status, input out_value, output ready);
endinterface

[rtl/tsq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack queue controller
// Sequences enqueue, stack transfer and pop operations on the datapath.
// ----------------------------------------------------------------------------
module tsq_ctrl import tsq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_action,
   input  logic      rsp_ready,
   input  flags_type flags,
   output logic      req_ready,
   output cmd_type   cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !flags.rsp_valid || rsp_ready;
            accept    = req_valid && req_ready;
            if (accept) begin
               if (req_action == ACTION_ENQ) begin
                  cmd.enq = 1'b1;
               end else if (!flags.out_empty) begin
                  cmd.pop_rd = 1'b1;
                  state_in   = ST_POP_WAIT;
               end else if (flags.in_empty) begin
                  cmd.load_empty = 1'b1;
               end else begin
                  state_in = ST_MOVE;
               end
            end
         end
         ST_MOVE: begin
            cmd.move_rd = !flags.in_empty;
            cmd.move_wr = flags.move_pend;
            if (flags.in_empty && !flags.move_pend) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            cmd.pop_rd = 1'b1;
            state_in   = ST_POP_WAIT;
         end
         ST_POP_WAIT: begin
            cmd.load_pop = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/tsq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack queue datapath
// Holds both stacks, their counts and the response register.
// ----------------------------------------------------------------------------
module tsq_datapath import tsq_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic signed [DATA_WIDTH-1:0] item_value,
   input  logic                         rsp_ready,
   output flags_type                    flags,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic signed [DATA_WIDTH-1:0] rsp_out_value
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [DATA_WIDTH-1:0] in_mem  [STACK_DEPTH];
   logic [DATA_WIDTH-1:0] out_mem [STACK_DEPTH];

   logic [CW-1:0]         in_count_ff, in_count_in;
   logic [CW-1:0]         out_count_ff, out_count_in;
   logic                  move_pend_ff;
   logic [DATA_WIDTH-1:0] in_rd_ff;
   logic [DATA_WIDTH-1:0] out_rd_ff;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [DATA_WIDTH-1:0] rsp_value_ff;

   logic          in_full;
   logic          do_push;
   logic [CW-1:0] in_top;
   logic [CW-1:0] out_top;

   assign in_full = (in_count_ff == CW'(STACK_DEPTH));
   assign do_push = cmd.enq && !in_full;
   assign in_top  = in_count_ff - CW'(1);
   assign out_top = out_count_ff - CW'(1);

   always_comb begin
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      if (do_push) begin
         in_count_in = in_count_ff + CW'(1);
      end else if (cmd.move_rd) begin
         in_count_in = in_top;
      end
      if (cmd.move_wr) begin
         out_count_in = out_count_ff + CW'(1);
      end else if (cmd.pop_rd) begin
         out_count_in = out_top;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
         move_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         move_pend_ff <= cmd.move_rd;
         if (cmd.enq || cmd.load_pop || cmd.load_empty) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         in_mem[in_count_ff[AW-1:0]] <= item_value;
      end
      if (cmd.move_rd) begin
         in_rd_ff <= in_mem[in_top[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.move_wr) begin
         out_mem[out_count_ff[AW-1:0]] <= in_rd_ff;
      end
      if (cmd.pop_rd) begin
         out_rd_ff <= out_mem[out_top[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enq) begin
         rsp_status_ff <= in_full ? STATUS_DROP : STATUS_ENQ;
         rsp_value_ff  <= item_value;
      end else if (cmd.load_pop) begin
         rsp_status_ff <= STATUS_DEQ;
         rsp_value_ff  <= out_rd_ff;
      end else if (cmd.load_empty) begin
         rsp_status_ff <= STATUS_EMPTY;
         rsp_value_ff  <= EMPTY_VALUE;
      end
   end

   assign flags.in_empty  = (in_count_ff == '0);
   assign flags.out_empty = (out_count_ff == '0);
   assign flags.move_pend = move_pend_ff;
   assign flags.rsp_valid = rsp_valid_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;

endmodule

[rtl/two_stack_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack queue
// First-in first-out queue built from an input stack and an output stack.
// ----------------------------------------------------------------------------
// The request channel carries an action bit and a 32-bit value; every
// accepted request word gives exactly one response word with a status and
// a value. An enqueue pushes onto the input stack, or is dropped with a
// drop status when that stack is full, and echoes its value. A dequeue pops
// the output stack; when that stack is empty, the whole input stack is first
// moved over one entry per cycle through the stack memory ports.
// An enqueue or a dequeue from an empty queue loads the response register
// directly; a pop reads the output stack top into a read register, which
// then loads the response register. Requests are taken only in the idle
// state, so one request is in work at a time.
// Synchronous reset empties both stacks and clears the response valid flag.
// A finished response waits in the response register while the receiver
// stalls; a new request is still taken if the receiver takes that response
// in the same cycle.
// ----------------------------------------------------------------------------
module two_stack_queue_top import tsq_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   tsq_req_if.sink   req_if,
   tsq_rsp_if.source rsp_if
);

   cmd_type   cmd;
   flags_type flags;

   tsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .rsp_ready  (rsp_if.ready),
      .flags      (flags),
      .req_ready  (req_if.ready),
      .cmd        (cmd)
   );

   tsq_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .item_value    (req_if.item_value),
      .rsp_ready     (rsp_if.ready),
      .flags         (flags),
      .rsp_valid     (rsp_if.valid),
      .rsp_status    (rsp_if.status),
      .rsp_out_value (rsp_if.out_value)
   );

endmodule
